[design/blob_moment_orientation_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for blob_moment_orientation
// Shorthand for clocked checks, sampled on clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef BLOB_MOMENT_ORIENTATION_MACROS_SVH
`define BLOB_MOMENT_ORIENTATION_MACROS_SVH

// same-cycle implication
`define BMO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bmo_pkg.sv]
// ---------------------------------------------------------------------------
// bmo_pkg
// Shared types and constants of the blob moment / orientation block.
// ---------------------------------------------------------------------------
package bmo_pkg;

    // moment arithmetic is modulo 2^64
    localparam int MOM_W = 64;
    typedef logic signed [MOM_W-1:0] mom_t;

    // angle accumulator, units of 2^-16 rad
    localparam int ZW = 21;
    typedef logic signed [ZW-1:0] zang_t;

    localparam int ANGLE_W      = 15;
    localparam int ANGLE_PI     = 205887;
    localparam int ANGLE_LIMIT  = 12868;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 5;

    localparam int LABEL_W = 5;
    localparam int CFG_W   = 24;
    localparam logic [CFG_W-1:0] MIN_SIZE_RESET = 24'd500;

    // normalization window for the vector magnitude
    localparam logic [MOM_W-1:0] NORM_TOP    = 64'h1000_0000_0000_0000; // 2^60
    localparam logic [MOM_W-1:0] NORM_LOW    = 64'h0200_0000_0000_0000; // 2^57
    localparam logic [MOM_W-1:0] NORM_COARSE = 64'h0002_0000_0000_0000; // 2^49

    // round(atan(2^-i) * 2^16)
    function automatic zang_t atan_entry(input logic [STEP_W-1:0] i);
        zang_t v;
        case (i)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/bmo_ram.sv]
// ---------------------------------------------------------------------------
// bmo_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/bmo_angle.sv]
// ---------------------------------------------------------------------------
// bmo_angle
// atan2(y, x) in Q3.12 radians: normalize, then 17 CORDIC vectoring steps.
// ---------------------------------------------------------------------------
module bmo_angle (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  bmo_pkg::mom_t                         vec_y,
    input  bmo_pkg::mom_t                         vec_x,
    output logic                                  done,
    output logic signed [bmo_pkg::ANGLE_W-1:0]    angle
);
    import bmo_pkg::*;

    localparam logic [1:0] AS_IDLE = 2'd0;
    localparam logic [1:0] AS_NORM = 2'd1;
    localparam logic [1:0] AS_ROT  = 2'd2;
    localparam logic [1:0] AS_FIN  = 2'd3;

    localparam zang_t Z_PI   = ZW'(ANGLE_PI);
    localparam zang_t Z_LIM  = ZW'(ANGLE_LIMIT);
    localparam zang_t Z_NLIM = -Z_LIM;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic [1:0]              state_reg, state_next;
    mom_t                    x_reg, x_next, y_reg, y_next;
    zang_t                   z_reg, z_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    done_reg, done_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;

    logic [MOM_W-1:0] mag_x, mag_y, mag_max;
    mom_t             xs, ys;
    zang_t            z_rnd;

    // magnitude of the larger component
    assign mag_x   = x_reg[MOM_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign mag_y   = y_reg[MOM_W-1] ? (~y_reg + 1'b1) : y_reg;
    assign mag_max = (mag_x > mag_y) ? mag_x : mag_y;

    assign xs    = x_reg >>> step_reg;
    assign ys    = y_reg >>> step_reg;
    assign z_rnd = (z_reg + ZW'(8)) >>> 4;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        case (state_reg)
            AS_IDLE:
            begin
                if (start)
                begin
                    x_next = vec_x;
                    y_next = vec_y;
                    if (vec_y == '0 && !vec_x[MOM_W-1])
                    begin
                        angle_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = AS_NORM;
                    end
                end
            end
            AS_NORM:
            begin
                if (mag_max >= NORM_TOP)
                begin
                    x_next = x_reg >>> 1;
                    y_next = y_reg >>> 1;
                end
                else if (mag_max < NORM_COARSE)
                begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end
                else if (mag_max < NORM_LOW)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                begin
                    // fold the left half-plane onto the right
                    if (x_reg[MOM_W-1])
                    begin
                        z_next = y_reg[MOM_W-1] ? -Z_PI : Z_PI;
                        x_next = -x_reg;
                        y_next = -y_reg;
                    end
                    else
                    begin
                        z_next = '0;
                    end
                    step_next  = '0;
                    state_next = AS_ROT;
                end
            end
            AS_ROT:
            begin
                if (!y_reg[MOM_W-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_entry(step_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_entry(step_reg);
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = AS_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            AS_FIN:
            begin
                if (z_rnd > Z_LIM)
                begin
                    angle_next = ANGLE_W'(Z_LIM);
                end
                else if (z_rnd < Z_NLIM)
                begin
                    angle_next = ANGLE_W'(Z_NLIM);
                end
                else
                begin
                    angle_next = ANGLE_W'(z_rnd);
                end
                done_next  = 1'b1;
                state_next = AS_IDLE;
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;
endmodule

[design/blob_moment_orientation.sv]
// ---------------------------------------------------------------------------
// blob_moment_orientation
// Per-region raw moments with centroid and principal angle report.
// ---------------------------------------------------------------------------
// Pixel beats (action 0) are taken one per cycle: the region's moment word is
// read from a RAM, updated and written back at the next clock edge, with a
// bypass for back-to-back hits on one label. A report beat (action 1) stalls
// the input while a walk over all REGION_SLOTS entries runs. A skipped region
// passes through read, check and next; a reported region through read, check,
// the shift-subtract centroid divide, the moment products and angle start,
// normalize, CORDIC, round and hand-off, then queue and next, plus waits on
// out_stall. An angle that is zero by the early test skips the normalize,
// CORDIC and round steps. A closing state queues the last beat. The report
// ends the walk by dropping all entry valid flags at once, so no clearing
// pass is needed and pixels are accepted again the cycle after the last
// report beat is queued.
`include "blob_moment_orientation_macros.svh"

module blob_moment_orientation #(
    parameter int REGION_SLOTS = 32,
    parameter int COORD_BITS   = 12,
    parameter int COUNT_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [bmo_pkg::CFG_W-1:0]           cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [COORD_BITS-1:0]               pixel_x,
    input  logic [COORD_BITS-1:0]               pixel_y,
    input  logic [bmo_pkg::LABEL_W-1:0]         region_label,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bmo_pkg::LABEL_W-1:0]         out_label,
    output logic [COUNT_BITS-1:0]               pixel_count,
    output logic [COORD_BITS-1:0]               centroid_x,
    output logic [COORD_BITS-1:0]               centroid_y,
    output logic signed [bmo_pkg::ANGLE_W-1:0]  angle,
    output logic                                none_found,
    output logic                                last
);
    import bmo_pkg::*;

    localparam int AW      = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int LXW     = LABEL_W + 2;
    localparam int SXW     = COORD_BITS + COUNT_BITS;
    localparam int SQW     = 2 * COORD_BITS + COUNT_BITS;
    localparam int PRW     = 2 * COORD_BITS;
    localparam int EW      = COUNT_BITS + 2 * SXW + 3 * SQW;
    localparam int OFF_SXY = 0;
    localparam int OFF_SYY = SQW;
    localparam int OFF_SXX = 2 * SQW;
    localparam int OFF_SY  = 3 * SQW;
    localparam int OFF_SX  = 3 * SQW + SXW;
    localparam int OFF_CNT = 3 * SQW + 2 * SXW;
    localparam int DIW     = $clog2(COORD_BITS);
    localparam int CMPW    = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int P1W     = COORD_BITS + SXW;
    localparam int R1W     = COUNT_BITS + PRW;
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [AW-1:0]         LAST_SLOT = AW'(REGION_SLOTS - 1);
    localparam logic signed [ANGLE_W-1:0] A_LIM = ANGLE_W'(ANGLE_LIMIT);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_MUL1 = 4'd4;
    localparam logic [3:0] ST_MUL2 = 4'd5;
    localparam logic [3:0] ST_MOM  = 4'd6;
    localparam logic [3:0] ST_AB   = 4'd7;
    localparam logic [3:0] ST_ANG  = 4'd8;
    localparam logic [3:0] ST_PUSH = 4'd9;
    localparam logic [3:0] ST_NEXT = 4'd10;
    localparam logic [3:0] ST_END  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    r_reg, r_next;
    logic [CFG_W-1:0] min_size_reg;

    // ------------------------------------------------------------------
    // input handshake and label decode
    // ------------------------------------------------------------------
    logic            in_acc, pix_go, lab_ok;
    logic [LXW-1:0]  lab_ext;
    logic [AW-1:0]   lab_addr;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign lab_ext  = LXW'(region_label);
    assign lab_ok   = lab_ext < LXW'(REGION_SLOTS);
    assign lab_addr = lab_ext[AW-1:0];
    assign pix_go   = in_acc && !action && lab_ok;

    // ------------------------------------------------------------------
    // pixel update stage: squares registered alongside the RAM read
    // ------------------------------------------------------------------
    logic            s1_valid_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic [PRW-1:0]  s1_xx_reg, s1_yy_reg, s1_xy_reg;
    logic [PRW-1:0]  px_xx, px_yy, px_xy;

    assign px_xx = pixel_x * pixel_x;
    assign px_yy = pixel_y * pixel_y;
    assign px_xy = pixel_x * pixel_y;

    logic [REGION_SLOTS-1:0] valid_reg;
    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    logic [EW-1:0]   fwd_data_reg;

    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    logic [EW-1:0]   old_ent, new_ent;
    logic            fwd_hit;

    assign ram_raddr = pix_go ? lab_addr : r_reg;
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
    assign old_ent   = fwd_hit ? fwd_data_reg
                     : (valid_reg[s1_addr_reg] ? ram_rdata : '0);

    // accumulate; a saturated count leaves the entry unchanged
    always_comb
    begin
        new_ent = old_ent;
        if (old_ent[OFF_CNT +: COUNT_BITS] != CNT_MAX)
        begin
            new_ent[OFF_CNT +: COUNT_BITS] = old_ent[OFF_CNT +: COUNT_BITS] + 1'b1;
            new_ent[OFF_SX +: SXW]  = old_ent[OFF_SX +: SXW] + SXW'(s1_x_reg);
            new_ent[OFF_SY +: SXW]  = old_ent[OFF_SY +: SXW] + SXW'(s1_y_reg);
            new_ent[OFF_SXX +: SQW] = old_ent[OFF_SXX +: SQW] + SQW'(s1_xx_reg);
            new_ent[OFF_SYY +: SQW] = old_ent[OFF_SYY +: SQW] + SQW'(s1_yy_reg);
            new_ent[OFF_SXY +: SQW] = old_ent[OFF_SXY +: SQW] + SQW'(s1_xy_reg);
        end
    end

    bmo_ram #(
        .WIDTH (EW),
        .DEPTH (REGION_SLOTS),
        .AW    (AW)
    ) u_moment_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (new_ent),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // report walk datapath
    // ------------------------------------------------------------------
    logic [EW-1:0]         walk_ent;
    logic                  qualify;
    logic [COUNT_BITS-1:0] c_reg;
    logic [SXW-1:0]        sx_reg, sy_reg, rem_x_reg, rem_y_reg;
    logic [SQW-1:0]        sxx_reg, syy_reg, sxy_reg;
    logic [COORD_BITS-1:0] q_x_reg, q_y_reg;
    logic [DIW-1:0]        div_i_reg;
    logic [SXW-1:0]        trial;
    logic [COORD_BITS-1:0] q_bit;
    logic [P1W-1:0]        p_xsx, p_ysy, p_xsy, p_ysx;
    logic [PRW-1:0]        p_xx, p_yy, p_xy;
    logic [R1W-1:0]        r_xx, r_yy, r_xy;
    logic [MOM_W-1:0]      p_xsx_reg, p_ysy_reg, p_xsy_reg, p_ysx_reg;
    logic [PRW-1:0]        p_xx_reg, p_yy_reg, p_xy_reg;
    logic [MOM_W-1:0]      r_xx_reg, r_yy_reg, r_xy_reg;
    mom_t                  mxx_reg, myy_reg, mxy_reg;

    assign walk_ent = valid_reg[r_reg] ? ram_rdata : '0;
    assign qualify  = (walk_ent[OFF_CNT +: COUNT_BITS] != '0) &&
                      (CMPW'(walk_ent[OFF_CNT +: COUNT_BITS]) >= CMPW'(min_size_reg));
    assign trial    = SXW'(c_reg) << div_i_reg;
    assign q_bit    = COORD_BITS'(1) << div_i_reg;

    assign p_xsx = q_x_reg * sx_reg;
    assign p_ysy = q_y_reg * sy_reg;
    assign p_xsy = q_x_reg * sy_reg;
    assign p_ysx = q_y_reg * sx_reg;
    assign p_xx  = q_x_reg * q_x_reg;
    assign p_yy  = q_y_reg * q_y_reg;
    assign p_xy  = q_x_reg * q_y_reg;
    assign r_xx  = c_reg * p_xx_reg;
    assign r_yy  = c_reg * p_yy_reg;
    assign r_xy  = c_reg * p_xy_reg;

    // angle unit
    logic                      ang_start, ang_done;
    mom_t                      ang_y, ang_x;
    logic signed [ANGLE_W-1:0] ang_val;

    assign ang_start = (state_reg == ST_AB);
    assign ang_y     = mxy_reg <<< 1;
    assign ang_x     = myy_reg - mxx_reg;

    bmo_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .vec_y (ang_y),
        .vec_x (ang_x),
        .done  (ang_done),
        .angle (ang_val)
    );

    // ------------------------------------------------------------------
    // pending line and output register
    // ------------------------------------------------------------------
    logic                      pend_valid_reg;
    logic [LABEL_W-1:0]        pend_label_reg;
    logic [COUNT_BITS-1:0]     pend_count_reg;
    logic [COORD_BITS-1:0]     pend_cx_reg, pend_cy_reg;
    logic signed [ANGLE_W-1:0] pend_angle_reg;

    logic                      out_valid_reg;
    logic [LABEL_W-1:0]        out_label_reg;
    logic [COUNT_BITS-1:0]     out_count_reg;
    logic [COORD_BITS-1:0]     out_cx_reg, out_cy_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic                      out_none_reg, out_last_reg;

    logic out_free, push_pend, fill_pend, end_go, load_out, empty_rep;

    assign out_free  = !out_valid_reg || !out_stall;
    assign push_pend = (state_reg == ST_PUSH) && pend_valid_reg && out_free;
    assign fill_pend = (state_reg == ST_PUSH) && (!pend_valid_reg || out_free);
    assign end_go    = (state_reg == ST_END) && out_free;
    assign load_out  = push_pend || end_go;
    assign empty_rep = end_go && !pend_valid_reg;

    // walk sequencer
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && action)
                begin
                    state_next = ST_RD;
                    r_next     = '0;
                end
            end
            ST_RD:   state_next = ST_CHK;
            ST_CHK:  state_next = qualify ? ST_DIV : ST_NEXT;
            ST_DIV:
            begin
                if (div_i_reg == '0)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MOM;
            ST_MOM:  state_next = ST_AB;
            ST_AB:   state_next = ST_ANG;
            ST_ANG:
            begin
                if (ang_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (fill_pend)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (r_reg == LAST_SLOT)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_END:
            begin
                if (end_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            r_reg          <= '0;
            min_size_reg   <= MIN_SIZE_RESET;
            s1_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_i_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            s1_valid_reg <= pix_go;
            if (cfg_write_en)
            begin
                min_size_reg <= cfg_write_data;
            end
            // entry flags: set on write, all dropped when the report ends
            if (s1_valid_reg)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
                fwd_valid_reg          <= 1'b1;
            end
            else if (end_go)
            begin
                valid_reg     <= '0;
                fwd_valid_reg <= 1'b0;
            end
            if (fill_pend)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (end_go)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CHK)
            begin
                div_i_reg <= DIW'(COORD_BITS - 1);
            end
            else if (state_reg == ST_DIV && div_i_reg != '0)
            begin
                div_i_reg <= div_i_reg - 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // pixel stage
        s1_addr_reg <= lab_addr;
        s1_x_reg    <= pixel_x;
        s1_y_reg    <= pixel_y;
        s1_xx_reg   <= px_xx;
        s1_yy_reg   <= px_yy;
        s1_xy_reg   <= px_xy;
        if (s1_valid_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_ent;
        end

        // entry latch and divide setup
        if (state_reg == ST_CHK)
        begin
            c_reg     <= walk_ent[OFF_CNT +: COUNT_BITS];
            sx_reg    <= walk_ent[OFF_SX +: SXW];
            sy_reg    <= walk_ent[OFF_SY +: SXW];
            sxx_reg   <= walk_ent[OFF_SXX +: SQW];
            syy_reg   <= walk_ent[OFF_SYY +: SQW];
            sxy_reg   <= walk_ent[OFF_SXY +: SQW];
            rem_x_reg <= walk_ent[OFF_SX +: SXW];
            rem_y_reg <= walk_ent[OFF_SY +: SXW];
            q_x_reg   <= '0;
            q_y_reg   <= '0;
        end

        // restoring divide, one quotient bit per cycle for both axes
        if (state_reg == ST_DIV)
        begin
            if (rem_x_reg >= trial)
            begin
                rem_x_reg <= rem_x_reg - trial;
                q_x_reg   <= q_x_reg | q_bit;
            end
            if (rem_y_reg >= trial)
            begin
                rem_y_reg <= rem_y_reg - trial;
                q_y_reg   <= q_y_reg | q_bit;
            end
        end

        // centroid products
        if (state_reg == ST_MUL1)
        begin
            p_xsx_reg <= MOM_W'(p_xsx);
            p_ysy_reg <= MOM_W'(p_ysy);
            p_xsy_reg <= MOM_W'(p_xsy);
            p_ysx_reg <= MOM_W'(p_ysx);
            p_xx_reg  <= p_xx;
            p_yy_reg  <= p_yy;
            p_xy_reg  <= p_xy;
        end
        if (state_reg == ST_MUL2)
        begin
            r_xx_reg <= MOM_W'(r_xx);
            r_yy_reg <= MOM_W'(r_yy);
            r_xy_reg <= MOM_W'(r_xy);
        end

        // central moments about the integer centroid
        if (state_reg == ST_MOM)
        begin
            mxx_reg <= MOM_W'(sxx_reg) - (p_xsx_reg << 1) + r_xx_reg;
            myy_reg <= MOM_W'(syy_reg) - (p_ysy_reg << 1) + r_yy_reg;
            mxy_reg <= MOM_W'(sxy_reg) - p_xsy_reg - p_ysx_reg + r_xy_reg;
        end

        // hold the newest line until the next one shows it is not last
        if (fill_pend)
        begin
            pend_label_reg <= LABEL_W'(r_reg);
            pend_count_reg <= c_reg;
            pend_cx_reg    <= q_x_reg;
            pend_cy_reg    <= q_y_reg;
            pend_angle_reg <= ang_val;
        end

        if (load_out)
        begin
            out_label_reg <= empty_rep ? '0 : pend_label_reg;
            out_count_reg <= empty_rep ? '0 : pend_count_reg;
            out_cx_reg    <= empty_rep ? '0 : pend_cx_reg;
            out_cy_reg    <= empty_rep ? '0 : pend_cy_reg;
            out_angle_reg <= empty_rep ? '0 : pend_angle_reg;
            out_none_reg  <= empty_rep;
            out_last_reg  <= end_go;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_label   = out_label_reg;
    assign pixel_count = out_count_reg;
    assign centroid_x  = out_cx_reg;
    assign centroid_y  = out_cy_reg;
    assign angle       = out_angle_reg;
    assign none_found  = out_none_reg;
    assign last        = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BMO_ASSERT_IMPL(a_none_is_last, out_valid_reg && out_none_reg, out_last_reg, "empty report beat without last")
    `BMO_ASSERT_IMPL(a_walk_no_write, state_reg != ST_IDLE, !s1_valid_reg, "moment write during report walk")
    `BMO_ASSERT_NEXT(a_report_clears, end_go, valid_reg == '0 && !fwd_valid_reg, "stores not cleared after report")
    `BMO_ASSERT_IMPL(a_angle_range, out_valid_reg, out_angle_reg <= A_LIM && out_angle_reg >= -A_LIM, "angle out of range")
endmodule
